>>> hw/rtl/vcio_pkg.sv
package vcio_pkg;

	localparam logic [9:0] PORT_CRTC_IDX0 = 10'h2D0;
	localparam logic [9:0] PORT_CRTC_DAT0 = 10'h2D1;
	localparam logic [9:0] PORT_CRTC_IDX1 = 10'h2D2;
	localparam logic [9:0] PORT_CRTC_DAT1 = 10'h2D3;
	localparam logic [9:0] PORT_CRTC_IDX2 = 10'h2D4;
	localparam logic [9:0] PORT_CRTC_DAT2 = 10'h2D5;
	localparam logic [9:0] PORT_CRTC_IDX3 = 10'h2D6;
	localparam logic [9:0] PORT_CRTC_DAT3 = 10'h2D7;
	localparam logic [9:0] PORT_MODE      = 10'h2D8;
	localparam logic [9:0] PORT_CONTROL   = 10'h2D9;
	localparam logic [9:0] PORT_STATUS    = 10'h2DA;
	localparam logic [9:0] PORT_TRAP_VAL  = 10'h2DB;
	localparam logic [9:0] PORT_NMI_RST   = 10'h2DC;
	localparam logic [9:0] PORT_PAGING    = 10'h2DD;
	localparam logic [9:0] PORT_PALETTE   = 10'h2DE;
	localparam logic [9:0] PORT_CGA_DAT0  = 10'h3D1;
	localparam logic [9:0] PORT_CGA_DAT1  = 10'h3D3;
	localparam logic [9:0] PORT_CGA_DAT2  = 10'h3D5;
	localparam logic [9:0] PORT_CGA_DAT3  = 10'h3D7;
	localparam logic [9:0] PORT_CGA_STAT  = 10'h3DA;
	localparam logic [5:0] CGA_PAGE       = 6'h3D;

	localparam logic [7:0] RD_IDLE        = 8'hFF;
	localparam logic [3:0] FAKE_TOGGLE    = 4'h9;

	localparam int CRTC_DEPTH = 32;
	localparam int PAL_DEPTH  = 16;

	typedef struct packed {
		logic       op;
		logic [9:0] port;
		logic [7:0] write_data;
		logic       hretrace;
		logic       vretrace;
		logic [3:0] palette_index;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       nmi_fire;
		logic       nmi_reset;
		logic       map_changed;
		logic       timing_changed;
		logic       rom_selected;
		logic [1:0] plane_select;
		logic [7:0] mode_value;
		logic [3:0] palette_color;
	} result_t;

	function automatic logic [7:0] crtc_mask(input logic [4:0] idx);
		logic [7:0] m;
		case (idx)
			5'd0, 5'd1, 5'd2, 5'd3:  m = 8'hFF;
			5'd4, 5'd6, 5'd7, 5'd10: m = 8'h7F;
			5'd5, 5'd9, 5'd11:       m = 8'h1F;
			5'd8:                    m = 8'hF3;
			5'd12, 5'd14:            m = 8'h3F;
			5'd13, 5'd15, 5'd16, 5'd17: m = 8'hFF;
			default:                 m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

>>> hw/rtl/vcio_regs.sv
module vcio_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_nmi,
	input  logic              fire,
	input  vcio_pkg::item_t   item,
	output vcio_pkg::result_t res
);
	import vcio_pkg::*;

	logic                  nmi_option_q;
	logic [4:0]            crtc_index_q;
	logic [7:0]            crtc_regs_q [CRTC_DEPTH];
	logic [7:0]            crtc_echo_q;
	logic [7:0]            trap_port_q;
	logic [7:0]            trap_value_q;
	logic [7:0]            control_q;
	logic [7:0]            mode_q;
	logic                  rom_in_q;
	logic [3:0]            fake_status_q;
	logic [3:0]            palette_q [PAL_DEPTH];
	logic [1:0]            plane_q;

	logic [4:0]            crtc_index_d;
	logic                  crtc_we;
	logic [7:0]            crtc_wdata;
	logic [7:0]            crtc_echo_d;
	logic [7:0]            trap_port_d;
	logic [7:0]            trap_value_d;
	logic [7:0]            control_d;
	logic [7:0]            mode_d;
	logic                  rom_in_d;
	logic [3:0]            fake_status_d;
	logic                  pal_we;
	logic [3:0]            pal_widx;
	logic [3:0]            pal_wdata;
	logic [1:0]            plane_d;
	logic [7:0]            crtc_cur;
	logic                  lpen;
	logic                  is_trap;

	assign crtc_cur  = crtc_regs_q[crtc_index_q];
	assign lpen      = nmi_option_q;
	assign is_trap   = item.port[9:4] == CGA_PAGE;
	assign pal_widx  = item.write_data[7:4];
	assign pal_wdata = ~item.write_data[3:0];
	assign crtc_wdata = item.write_data & crtc_mask(crtc_index_q);

	always_comb begin
		crtc_index_d   = crtc_index_q;
		crtc_we        = 1'b0;
		crtc_echo_d    = crtc_echo_q;
		trap_port_d    = trap_port_q;
		trap_value_d   = trap_value_q;
		control_d      = control_q;
		mode_d         = mode_q;
		rom_in_d       = rom_in_q;
		fake_status_d  = fake_status_q;
		pal_we         = 1'b0;
		plane_d        = plane_q;
		res            = '0;
		res.read_data  = RD_IDLE;

		if (item.op) begin
			if (is_trap) begin
				trap_port_d  = {4'h0, item.port[3:0]};
				trap_value_d = item.write_data;
				if (nmi_option_q && control_q[5]) begin
					trap_port_d[7] = 1'b1;
					res.nmi_fire   = 1'b1;
				end
				if (item.port == PORT_CGA_DAT0)
					crtc_echo_d = item.write_data;
			end else begin
				case (item.port)
					PORT_CRTC_IDX0, PORT_CRTC_IDX1, PORT_CRTC_IDX2, PORT_CRTC_IDX3: begin
						crtc_index_d = item.write_data[4:0];
					end
					PORT_CRTC_DAT0, PORT_CRTC_DAT1, PORT_CRTC_DAT2, PORT_CRTC_DAT3: begin
						crtc_we = 1'b1;
						// compare against the unmasked byte; cursor/start regs 14-16 excluded
						if (crtc_cur != item.write_data &&
						    (crtc_index_q < 5'd14 || crtc_index_q > 5'd16))
							res.timing_changed = 1'b1;
					end
					PORT_MODE:     mode_d = item.write_data;
					PORT_CONTROL:  control_d = item.write_data;
					PORT_TRAP_VAL: trap_port_d[7] = 1'b0;
					PORT_NMI_RST: begin
						res.nmi_reset  = 1'b1;
						trap_port_d[7] = 1'b0;
					end
					PORT_PAGING: begin
						res.map_changed = rom_in_q;
						rom_in_d        = 1'b0;
					end
					PORT_PALETTE: begin
						if (control_q[0])
							pal_we = 1'b1;
						else
							plane_d = item.write_data[1:0];
					end
					default: ;
				endcase
			end
		end else begin
			case (item.port)
				PORT_CRTC_IDX0, PORT_CRTC_IDX1, PORT_CRTC_IDX2, PORT_CRTC_IDX3: begin
					res.read_data = {3'b000, crtc_index_q};
				end
				PORT_CRTC_DAT0, PORT_CRTC_DAT1, PORT_CRTC_DAT2, PORT_CRTC_DAT3: begin
					res.read_data = crtc_cur;
				end
				PORT_STATUS: begin
					res.read_data = {control_q[7:5], item.vretrace, 1'b0, lpen, 1'b0,
					                 item.hretrace};
				end
				PORT_TRAP_VAL: res.read_data = trap_value_q;
				PORT_NMI_RST:  res.read_data = trap_port_q;
				PORT_PAGING: begin
					res.read_data   = {rom_in_q, 7'h00};
					res.map_changed = ~rom_in_q;
					rom_in_d        = 1'b1;
				end
				PORT_CGA_DAT0, PORT_CGA_DAT1, PORT_CGA_DAT2, PORT_CGA_DAT3: begin
					res.read_data = crtc_echo_q;
				end
				PORT_CGA_STAT: begin
					if (mode_q[3]) begin
						res.read_data = {4'h0, item.vretrace, lpen, 1'b0, item.hretrace};
					end else begin
						// display off: toggle fake retrace bits on every read
						fake_status_d = fake_status_q ^ FAKE_TOGGLE;
						res.read_data = {4'h0, fake_status_d};
					end
				end
				default: ;
			endcase
		end

		res.rom_selected  = rom_in_d;
		res.plane_select  = plane_d;
		res.mode_value    = mode_d;
		res.palette_color = (pal_we && pal_widx == item.palette_index) ? pal_wdata
		                                                                : palette_q[item.palette_index];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nmi_option_q <= 1'b1;
		end else if (cfg_we) begin
			nmi_option_q <= cfg_nmi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crtc_index_q  <= '0;
			crtc_echo_q   <= '0;
			trap_port_q   <= '0;
			trap_value_q  <= '0;
			control_q     <= '0;
			mode_q        <= '0;
			rom_in_q      <= 1'b1;
			fake_status_q <= '0;
			plane_q       <= '0;
			for (int i = 0; i < CRTC_DEPTH; i++)
				crtc_regs_q[i] <= '0;
			for (int j = 0; j < PAL_DEPTH; j++)
				palette_q[j] <= '0;
		end else if (fire) begin
			crtc_index_q  <= crtc_index_d;
			crtc_echo_q   <= crtc_echo_d;
			trap_port_q   <= trap_port_d;
			trap_value_q  <= trap_value_d;
			control_q     <= control_d;
			mode_q        <= mode_d;
			rom_in_q      <= rom_in_d;
			fake_status_q <= fake_status_d;
			plane_q       <= plane_d;
			if (crtc_we)
				crtc_regs_q[crtc_index_q] <= crtc_wdata;
			if (pal_we)
				palette_q[pal_widx] <= pal_wdata;
		end
	end

endmodule

>>> hw/rtl/video_card_io_register_file_top.sv
// I/O register file of a CGA-compatible video card.
// Input channel (in_valid/in_stall): one bus access per beat; op selects read
// or write, port is the I/O address, write_data the byte written, and the
// retrace flags and palette_index are sampled with the access.
// Output channel (out_valid/out_stall): one result beat per access, in order,
// carrying the read byte, the NMI/paging/timing pulses and the current
// paging, plane, mode and palette lookup after that access.
// Configuration channel (cfg_valid/cfg_ready): writes nmi_option from
// cfg_data; cfg_ready is always high. Write it only while the block is idle.
// An accepted beat is held in the input register, decoded and applied to the
// registers when it advances; its result then goes to the result register.
// Throughput: one access per cycle while the receiver does not stall, set by
// the single decode stage between the input register and the result register.
// When the receiver stalls, the result register holds; the decode stage then
// holds its beat and in_stall rises once that stage is occupied.
// Reset: nmi_option = 1, ROM overlay paged in, all other registers, CRTC
// registers and palette entries cleared; both channels empty.
module video_card_io_register_file_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [9:0] port,
	input  logic [7:0] write_data,
	input  logic       hretrace,
	input  logic       vretrace,
	input  logic [3:0] palette_index,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       nmi_fire,
	output logic       nmi_reset,
	output logic       map_changed,
	output logic       timing_changed,
	output logic       rom_selected,
	output logic [1:0] plane_select,
	output logic [7:0] mode_value,
	output logic [3:0] palette_color,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);
	import vcio_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res;
	logic    advance;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	vcio_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_nmi (cfg_data),
		.fire    (advance),
		.item    (item_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// hold the beat while stalled
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= '{op, port, write_data, hretrace, vretrace, palette_index};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign read_data      = res_q.read_data;
	assign nmi_fire       = res_q.nmi_fire;
	assign nmi_reset      = res_q.nmi_reset;
	assign map_changed    = res_q.map_changed;
	assign timing_changed = res_q.timing_changed;
	assign rom_selected   = res_q.rom_selected;
	assign plane_select   = res_q.plane_select;
	assign mode_value     = res_q.mode_value;
	assign palette_color  = res_q.palette_color;

endmodule
